[rtl/sfr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the stream find-and-replace core.
// ----------------------------------------------------------------------------
package sfr_pkg;

   // byte slots in the 64-bit pattern and replacement registers
   localparam int BYTE_SLOTS          = 8;
   localparam int MAX_PATTERN_DEF     = 8;
   localparam int MAX_REPLACEMENT_DEF = 8;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_BYTES      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PATTERN_LENGTH     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_BYTES  = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPLACEMENT_LENGTH = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DROP,
      ST_REPL,
      ST_BARE
   } sfr_state_type;

   // control from the sequencer into the window chain
   typedef struct packed {
      logic load;
      logic shift;
   } win_ctl_type;

   // status from the window chain back to the sequencer
   typedef struct packed {
      logic [7:0] head;
      logic       prefix;
      logic       shift_prefix;
   } win_status_type;

endpackage : sfr_pkg
`default_nettype wire

[rtl/sfr_cell.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_cell
// One window slot: holds a byte, loads a new one or takes its right neighbor's
// byte on a shift, and compares against its own and the previous pattern byte.
// ----------------------------------------------------------------------------
module sfr_cell (
   input  wire logic       clock,
   input  wire logic       load,
   input  wire logic       shift,
   input  wire logic [7:0] load_byte,
   input  wire logic [7:0] next_byte,
   input  wire logic [7:0] pat_cur,
   input  wire logic [7:0] pat_prev,
   output logic      [7:0] win_byte,
   output logic            match_cur,
   output logic            match_sh
);
   logic [7:0] win_ff;
   logic [7:0] win_in;

   always_comb begin
      win_in = win_ff;
      if (shift) begin
         win_in = next_byte;
      end else if (load) begin
         win_in = load_byte;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   assign win_byte  = win_ff;
   assign match_cur = (win_ff == pat_cur);
   // compare as if the window had already moved one place to the left
   assign match_sh  = (win_ff == pat_prev);

endmodule : sfr_cell
`default_nettype wire

[rtl/sfr_window.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sfr_window
// Row of window cells. Reports the head byte and whether the held bytes, as
// they are and after one shift, still form a prefix of the pattern.
// ----------------------------------------------------------------------------
module sfr_window #(
   parameter int DEPTH = sfr_pkg::MAX_PATTERN_DEF
) (
   input  wire logic                         clock,
   input  wire sfr_pkg::win_ctl_type         ctl,
   input  wire logic [$clog2(DEPTH+1)-1:0]   load_pos,
   input  wire logic [$clog2(DEPTH+1)-1:0]   count,
   input  wire logic [7:0]                   load_byte,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0] pattern,
   output sfr_pkg::win_status_type           status
);
   import sfr_pkg::*;

   localparam int CW = $clog2(DEPTH+1);

   logic [7:0]       win_byte [DEPTH];
   logic [DEPTH-1:0] match_cur;
   logic [DEPTH-1:0] match_sh;
   logic [DEPTH-1:0] in_win;
   logic [DEPTH-1:0] in_shift;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [7:0] next_byte;
      logic [7:0] pat_prev;

      if (i == DEPTH-1) begin : g_tail
         assign next_byte = 8'h00;
      end else begin : g_body
         assign next_byte = win_byte[i+1];
      end

      if (i == 0) begin : g_first
         assign pat_prev    = pattern[7:0];
         assign in_shift[i] = 1'b0;
      end else begin : g_rest
         assign pat_prev    = pattern[8*(i-1) +: 8];
         assign in_shift[i] = (CW'(i) < count);
      end

      assign in_win[i] = (CW'(i) < count);

      sfr_cell u_cell (
         .clock     (clock),
         .load      (ctl.load && (load_pos == CW'(i))),
         .shift     (ctl.shift),
         .load_byte (load_byte),
         .next_byte (next_byte),
         .pat_cur   (pattern[8*i +: 8]),
         .pat_prev  (pat_prev),
         .win_byte  (win_byte[i]),
         .match_cur (match_cur[i]),
         .match_sh  (match_sh[i])
      );
   end

   assign status.head         = win_byte[0];
   assign status.prefix       = &(~in_win | match_cur);
   assign status.shift_prefix = &(~in_shift | match_sh);

endmodule : sfr_window
`default_nettype wire

[rtl/stream_find_replace_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// stream_find_replace_core
// Byte stream find-and-replace: every leftmost, non-overlapping occurrence of
// the pattern is replaced, bytes that cannot start a match pass through.
// ----------------------------------------------------------------------------
// order: a byte is taken in the idle state and classified in the eval state;
//   its result beats then go into the output register one by one as it frees
// flow: a new byte is taken only once the 0 to 8 result beats of the last one
//   have been put into the single-beat output register by the sequencer
// reset: window empty, all configuration registers zero (pass-through), no
//   beat pending on the result side
// ----------------------------------------------------------------------------
module stream_find_replace_core #(
   parameter int MAX_PATTERN     = sfr_pkg::MAX_PATTERN_DEF,
   parameter int MAX_REPLACEMENT = sfr_pkg::MAX_REPLACEMENT_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // input stream
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,   // in_byte
   input  wire logic                              req_tlast,   // in_end
   // result stream
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [7:0]                             rsp_tdata,   // out_byte
   output logic [1:0]                             rsp_tuser,   // has_byte, run_last
   output logic                                   rsp_tlast,   // string_end
   // configuration
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [sfr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]    csr_data
);
   import sfr_pkg::*;

   localparam int WIN_DEPTH = (MAX_PATTERN < BYTE_SLOTS) ? MAX_PATTERN : BYTE_SLOTS;
   localparam int REP_DEPTH = (MAX_REPLACEMENT < BYTE_SLOTS) ? MAX_REPLACEMENT : BYTE_SLOTS;
   localparam int CW        = $clog2(WIN_DEPTH+1);
   localparam int RW        = $clog2(REP_DEPTH+1);

   sfr_state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] pattern_ff;
   logic [3:0]            plen_ff;
   logic [CSR_DATA_W-1:0] rep_ff;
   logic [3:0]            rlen_ff;

   logic [CW-1:0] count_ff, count_in;
   logic          last_ff, last_in;
   logic [RW-1:0] rep_idx_ff, rep_idx_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_has_ff, rsp_has_in;
   logic       rsp_end_ff, rsp_end_in;
   logic       rsp_run_ff, rsp_run_in;

   logic [CW-1:0]  plen_eff;
   logic [RW-1:0]  rlen_eff;
   logic [CW-1:0]  load_pos;
   logic [7:0]     rep_byte;
   logic           accept;
   logic           csr_write;
   logic           out_free;
   logic           full_match;
   logic           need_drop;
   logic           drop_more;
   logic           rep_done;
   logic           emit;
   logic [7:0]     emit_byte;
   logic           emit_has;
   logic           emit_end;
   logic           emit_run;
   win_ctl_type    win_ctl;
   win_status_type win_status;

   assign plen_eff = (plen_ff > 4'(WIN_DEPTH)) ? CW'(WIN_DEPTH) : CW'(plen_ff);
   assign rlen_eff = (rlen_ff > 4'(REP_DEPTH)) ? RW'(REP_DEPTH) : RW'(rlen_ff);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign csr_write  = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // a stale count at or beyond the pattern length restarts the window
   assign load_pos = (count_ff >= plen_eff) ? '0 : count_ff;

   assign full_match = (plen_eff != '0) && (count_ff == plen_eff) && win_status.prefix;
   assign need_drop  = !((count_ff < plen_eff) && win_status.prefix) || last_ff;
   // at end of string the whole window drains through the drop path
   assign drop_more  = (count_ff > CW'(1)) && (last_ff || !win_status.shift_prefix);
   assign rep_done   = (rep_idx_ff == (rlen_eff - RW'(1)));

   always_comb begin
      rep_byte = 8'h00;
      for (int k = 0; k < REP_DEPTH; k++) begin
         if (rep_idx_ff == RW'(k)) begin
            rep_byte = rep_ff[8*k +: 8];
         end
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (plen_eff == '0) begin
               state_in = ST_DROP;
            end else if (full_match) begin
               if (rlen_eff != '0) begin
                  state_in = ST_REPL;
               end else if (last_ff) begin
                  state_in = ST_BARE;
               end else begin
                  state_in = ST_IDLE;
               end
            end else if (need_drop) begin
               state_in = ST_DROP;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DROP: begin
            if (out_free && !drop_more) begin
               state_in = ST_IDLE;
            end
         end
         ST_REPL: begin
            if (out_free && rep_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_BARE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath control and result beats
   always_comb begin
      count_in      = count_ff;
      last_in       = last_ff;
      rep_idx_in    = rep_idx_ff;
      win_ctl.load  = 1'b0;
      win_ctl.shift = 1'b0;
      emit          = 1'b0;
      emit_byte     = 8'h00;
      emit_has      = 1'b1;
      emit_end      = 1'b0;
      emit_run      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               win_ctl.load = 1'b1;
               count_in     = load_pos + CW'(1);
               last_in      = req_tlast;
            end
         end
         ST_EVAL: begin
            if ((plen_eff != '0) && full_match) begin
               count_in   = '0;
               rep_idx_in = '0;
            end
         end
         ST_DROP: begin
            if (out_free) begin
               emit          = 1'b1;
               emit_byte     = win_status.head;
               emit_run      = !drop_more;
               emit_end      = last_ff && !drop_more;
               win_ctl.shift = 1'b1;
               count_in      = count_ff - CW'(1);
            end
         end
         ST_REPL: begin
            if (out_free) begin
               emit       = 1'b1;
               emit_byte  = rep_byte;
               emit_run   = rep_done;
               emit_end   = last_ff && rep_done;
               rep_idx_in = rep_idx_ff + RW'(1);
            end
         end
         ST_BARE: begin
            if (out_free) begin
               emit     = 1'b1;
               emit_has = 1'b0;
               emit_run = 1'b1;
               emit_end = 1'b1;
            end
         end
         default: begin
         end
      endcase
      // a new pattern empties the window, held bytes are dropped
      if (csr_write && (csr_index inside {CSR_PATTERN_BYTES, CSR_PATTERN_LENGTH})) begin
         count_in = '0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_has_in   = rsp_has_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_run_in   = rsp_run_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_has_in   = emit_has;
         rsp_end_in   = emit_end;
         rsp_run_in   = emit_run;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         rep_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         pattern_ff   <= '0;
         plen_ff      <= '0;
         rep_ff       <= '0;
         rlen_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         last_ff      <= last_in;
         rep_idx_ff   <= rep_idx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            unique case (csr_index)
               CSR_PATTERN_BYTES:      pattern_ff <= csr_data;
               CSR_PATTERN_LENGTH:     plen_ff    <= csr_data[3:0];
               CSR_REPLACEMENT_BYTES:  rep_ff     <= csr_data;
               CSR_REPLACEMENT_LENGTH: rlen_ff    <= csr_data[3:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_run_ff  <= rsp_run_in;
   end

   sfr_window #(
      .DEPTH (WIN_DEPTH)
   ) u_window (
      .clock     (clock),
      .ctl       (win_ctl),
      .load_pos  (load_pos),
      .count     (count_ff),
      .load_byte (req_tdata),
      .pattern   (pattern_ff),
      .status    (win_status)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = {rsp_run_ff, rsp_has_ff};
   assign rsp_tlast  = rsp_end_ff;

   // the window never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(WIN_DEPTH))
      else $error("window count beyond depth");

   // the appended byte leaves the window nonempty unless a pattern write cleared it
   a_eval_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EVAL |-> count_ff != '0)
      else $error("empty window in classify step");

   // end of string closes the run of the byte that caused it
   a_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[1])
      else $error("string end without run end");

   // a bare marker only stands for an end of string
   a_bare_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tlast)
      else $error("bare marker not at string end");

   // the drop path leaves the window empty after the last beat of a string
   a_drain_on_end: assert property (@(posedge clock) disable iff (reset)
      emit && emit_end |=> count_ff == '0)
      else $error("window not drained at string end");

endmodule : stream_find_replace_core
`default_nettype wire

[bench/tb_stream_find_replace_core.sv]
// ----------------------------------------------------------------------------
// tb_stream_find_replace_core
// Self-checking bench for the stream find-and-replace core. A built-in
// predictor follows every accepted byte and every register write, and each
// result beat is checked field by field against the oldest beat it predicts.
// The stimulus runs a directed opening, then random strings under pattern and
// replacement settings; all but the last two stall both streams at random.
// ----------------------------------------------------------------------------
module tb_stream_find_replace_core;
   timeunit 1ns;
   timeprecision 1ps;

   import sfr_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       string_end;
      logic       run_last;
   } result_beat_type;

   class find_replace_scoreboard;
      logic [63:0]     pattern_word;
      logic [3:0]      pattern_len;
      logic [63:0]     replace_word;
      logic [3:0]      replace_len;
      logic [7:0]      window [8];
      int unsigned     held;
      result_beat_type due_beats [$];
      int              mismatches;

      function new();
         pattern_word = '0;
         pattern_len  = '0;
         replace_word = '0;
         replace_len  = '0;
         held         = 0;
         mismatches   = 0;
         foreach (window[i]) window[i] = '0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_PATTERN_BYTES: begin
               pattern_word = val;
               held = 0;
            end
            CSR_PATTERN_LENGTH: begin
               pattern_len = val[3:0];
               held = 0;
            end
            CSR_REPLACEMENT_BYTES:  replace_word = val;
            CSR_REPLACEMENT_LENGTH: replace_len = val[3:0];
            default: ;
         endcase
      endfunction

      function bit window_is_prefix();
         for (int i = 0; i < held; i++)
            if (window[i] != pattern_word[8*i +: 8]) return 1'b0;
         return 1'b1;
      endfunction

      function void push_beat(ref result_beat_type run [$], input logic [7:0] b,
                              input logic has);
         result_beat_type beat;
         beat.data       = b;
         beat.has_byte   = has;
         beat.string_end = 1'b0;
         beat.run_last   = 1'b0;
         run.push_back(beat);
      endfunction

      // predict the beats caused by one accepted input byte
      function void absorb_byte(logic [7:0] b, logic last);
         result_beat_type run [$];
         int unsigned plen;
         int unsigned rlen;
         plen = (pattern_len > 8) ? 8 : pattern_len;
         rlen = (replace_len > 8) ? 8 : replace_len;
         if (plen == 0) begin
            held = 0;
            push_beat(run, b, 1'b1);
         end else begin
            if (held >= plen) held = 0;
            window[held] = b;
            held++;
            if (held == plen && window_is_prefix()) begin
               for (int i = 0; i < rlen; i++) push_beat(run, replace_word[8*i +: 8], 1'b1);
               held = 0;
            end else begin
               while (held > 0 && !(held < plen && window_is_prefix())) begin
                  push_beat(run, window[0], 1'b1);
                  for (int i = 0; i < 7; i++) window[i] = window[i+1];
                  held--;
               end
            end
         end
         if (last) begin
            for (int i = 0; i < held; i++) push_beat(run, window[i], 1'b1);
            held = 0;
            if (run.size() == 0) push_beat(run, 8'h00, 1'b0);
            run[run.size()-1].string_end = 1'b1;
         end
         if (run.size() > 0) run[run.size()-1].run_last = 1'b1;
         foreach (run[i]) due_beats.push_back(run[i]);
      endfunction

      function void check_beat(result_beat_type got);
         result_beat_type want;
         if (due_beats.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected beat data %02h has %b end %b last %b",
                        $realtime, got.data, got.has_byte, got.string_end, got.run_last);
            return;
         end
         want = due_beats.pop_front();
         if (got.data !== want.data || got.has_byte !== want.has_byte ||
             got.string_end !== want.string_end || got.run_last !== want.run_last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: beat mismatch, want data %02h has %b end %b last %b, ",
                        $realtime, want.data, want.has_byte, want.string_end,
                        want.run_last, "got data %02h has %b end %b last %b",
                        got.data, got.has_byte, got.string_end, got.run_last);
         end
      endfunction

      function int pending();
         return due_beats.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;   // in_byte
   logic                   req_tlast  = 1'b0; // in_end
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;         // out_byte
   logic [1:0]             rsp_tuser;         // has_byte, run_last
   logic                   rsp_tlast;         // string_end
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   find_replace_scoreboard sb = new();

   int          send_idle = 15;
   int          recv_idle = 67;
   logic [7:0]  alphabet [4];
   logic [63:0] cur_pattern;
   int          cur_plen;

   stream_find_replace_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_beat({rsp_tdata, rsp_tuser[0], rsp_tlast, rsp_tuser[1]});
   end

   task automatic send_byte(input logic [7:0] b, input logic last);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      sb.absorb_byte(b, last);
   endtask

   task automatic send_text(input string s, input bit with_end);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], with_end && (i == s.len() - 1));
   endtask

   // hold the input off until every predicted beat is out, then let the core settle
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, val);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic new_setting(input int k);
      int          plen;
      int          rlen;
      logic [63:0] word;
      for (int i = 0; i < 4; i++) alphabet[i] = 8'($urandom);
      for (int i = 0; i < 8; i++) word[8*i +: 8] = alphabet[$urandom_range(3)];
      case (k)
         1: begin
            plen = 1;
            rlen = 8;
         end
         2: begin
            plen = 8;
            rlen = 8;
         end
         3: begin
            // both lengths beyond the limit, saturated by the core
            plen = 15;
            rlen = 12;
         end
         4: begin
            plen = 0;
            rlen = $urandom_range(8);
         end
         5: begin
            plen = $urandom_range(4, 2);
            rlen = 0;
         end
         6: begin
            plen = $urandom_range(15);
            rlen = $urandom_range(15);
         end
         default: begin
            plen = $urandom_range(8, 1);
            rlen = $urandom_range(8);
         end
      endcase
      cur_pattern = word;
      cur_plen    = (plen > 8) ? 8 : plen;
      write_csr(CSR_PATTERN_BYTES, word);
      write_csr(CSR_PATTERN_LENGTH, {60'd0, 4'(plen)});
      write_csr(CSR_REPLACEMENT_BYTES, {$urandom, $urandom});
      write_csr(CSR_REPLACEMENT_LENGTH, {60'd0, 4'(rlen)});
   endtask

   // strings seeded with whole or partial copies of the pattern
   task automatic run_random_strings(input int target);
      int         sent;
      int         len;
      int         pick;
      int         run_len;
      logic [7:0] text [$];
      sent = 0;
      while (sent < target) begin
         text.delete();
         len = $urandom_range(12, 1);
         while (text.size() < len) begin
            pick = $urandom_range(99);
            if (pick < 35 && cur_plen > 0) begin
               run_len = ($urandom_range(2) == 0) ? $urandom_range(cur_plen, 1) : cur_plen;
               for (int j = 0; j < run_len; j++) text.push_back(cur_pattern[8*j +: 8]);
            end else if (pick < 85) begin
               text.push_back(alphabet[$urandom_range(3)]);
            end else begin
               text.push_back(8'($urandom));
            end
         end
         for (int j = 0; j < text.size(); j++) send_byte(text[j], j == text.size() - 1);
         sent += text.size();
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // pass-through straight out of reset
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      wait_drained();

      write_csr(CSR_PATTERN_BYTES, 64'h0000_0000_0063_6261);
      write_csr(CSR_PATTERN_LENGTH, 64'd3);
      write_csr(CSR_REPLACEMENT_BYTES, 64'h0000_0000_0000_5958);
      write_csr(CSR_REPLACEMENT_LENGTH, 64'd2);
      send_text("zabcabd", 1'b1);
      send_text("ab", 1'b1);
      wait_drained();

      // a match that replaces with nothing at end of string leaves a bare marker
      write_csr(CSR_REPLACEMENT_LENGTH, 64'd0);
      send_text("abc", 1'b1);

      // held bytes are dropped when the pattern changes mid-string
      send_text("ab", 1'b0);
      wait_drained();
      write_csr(CSR_PATTERN_LENGTH, 64'd2);
      send_text("z", 1'b1);
      wait_drained();

      write_csr(CSR_PATTERN_BYTES, 64'hffff_ffff_ffff_ffff);
      write_csr(CSR_PATTERN_LENGTH, 64'd15);
      write_csr(CSR_REPLACEMENT_BYTES, 64'h0011_2233_4455_6677);
      write_csr(CSR_REPLACEMENT_LENGTH, 64'd12);
      for (int i = 0; i < 8; i++) send_byte(8'hff, i == 7);

      for (int k = 0; k < 7; k++) begin
         if (k < 3) begin
            send_idle = 15;
            recv_idle = 67;
         end else if (k < 5) begin
            send_idle = 67;
            recv_idle = 15;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         wait_drained();
         new_setting(k);
         run_random_strings(33);
      end

      wait_drained();
      repeat (12) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
